// ===== rtl/rwcc_pkg.sv =====
// Shared constants and types for the RGB window convolution core.
`default_nettype none
package rwcc_pkg;
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_KERNEL_DEF = 5;
   localparam int COEF_BITS_DEF  = 12;
   localparam int SCALE_FRAC_DEF = 16;
   localparam int SCALE_BITS     = 18;
   localparam int PIX_BITS       = 24;
   localparam int CSR_DATA_BITS  = 60;
   localparam int CSR_IDX_BITS   = 3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_COEF_0 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_COEF_1 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_COEF_2 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_COEF_3 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_COEF_4 = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_SCALE  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_LARGE  = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_DIMS   = 3'd7;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 18'd65536;
   localparam logic [31:0]           DIMS_RESET  = 32'd31457920;

   // per-channel accumulator controls
   typedef struct packed {
      logic clear;
      logic acc;
      logic mul_lo;
      logic mul_hi;
   } mac_ctl_type;
endpackage
`default_nettype wire

// ===== rtl/rwcc_cell.sv =====
// One window cell: holds a pixel, shifts on load, rotates during the sum.
`default_nettype none
module rwcc_cell
   import rwcc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                load_en,
   input  wire logic                rot_en,
   input  wire logic [PIX_BITS-1:0] load_d,
   input  wire logic [PIX_BITS-1:0] rot_d,
   output logic      [PIX_BITS-1:0] q
);
   logic [PIX_BITS-1:0] pix_ff, pix_in;

   always_comb begin
      pix_in = pix_ff;
      if (load_en) begin
         pix_in = load_d;
      end else if (rot_en) begin
         pix_in = rot_d;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign q = pix_ff;
endmodule
`default_nettype wire

// ===== rtl/rwcc_mac.sv =====
// Per-channel multiply-accumulate, scale, truncate toward zero and clamp.
`default_nettype none
module rwcc_mac
   import rwcc_pkg::*;
#(
   parameter int COEF_BITS       = COEF_BITS_DEF,
   parameter int SCALE_FRAC_BITS = SCALE_FRAC_DEF
) (
   input  wire logic                   clock,
   input  wire mac_ctl_type            ctl,
   input  wire logic [COEF_BITS-1:0]   coef,
   input  wire logic [7:0]             pix,
   input  wire logic [SCALE_BITS-1:0]  scale,
   output logic      [7:0]             result
);
   localparam int SUM_W  = COEF_BITS + 13;
   localparam int LO_W   = 13;
   localparam int HI_W   = SUM_W - LO_W;
   localparam int PLO_W  = LO_W + 1 + SCALE_BITS;
   localparam int PHI_W  = HI_W + SCALE_BITS;
   localparam int PROD_W = SUM_W + SCALE_BITS + 1;
   localparam int Q_W    = PROD_W - SCALE_FRAC_BITS;

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [PLO_W-1:0]  plo_ff;
   logic signed [PHI_W-1:0]  phi_ff;
   logic signed [COEF_BITS+8:0] term;
   logic signed [PROD_W-1:0] prod, adj;
   logic signed [Q_W-1:0]    quo;

   // coefficient times unsigned sample
   assign term = $signed(coef) * $signed({1'b0, pix});

   always_comb begin
      sum_in = sum_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.acc) begin
         sum_in = sum_ff + SUM_W'(term);
      end
   end

   // scale multiply split into low and high halves of the sum
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (ctl.mul_lo) begin
         plo_ff <= $signed({1'b0, sum_ff[LO_W-1:0]}) * $signed(scale);
      end
      if (ctl.mul_hi) begin
         phi_ff <= $signed(sum_ff[SUM_W-1:LO_W]) * $signed(scale);
      end
   end

   // recombine, truncate toward zero, clamp
   always_comb begin
      prod = (PROD_W'(phi_ff) <<< LO_W) + PROD_W'(plo_ff);
      adj  = prod;
      if (prod[PROD_W-1]) begin
         adj = prod + PROD_W'((64'd1 << SCALE_FRAC_BITS) - 64'd1);
      end
      quo = Q_W'(adj >>> SCALE_FRAC_BITS);
      if (quo < 0) begin
         result = 8'd0;
      end else if (quo > Q_W'(255)) begin
         result = 8'd255;
      end else begin
         result = quo[7:0];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/rgb_window_convolution_clamp_core.sv =====
// Top level of the RGB window convolution core with line store and window cells.
//
// RGB pixels enter in raster order; each one yields (after a lag of h rows plus
// h columns, h = half the kernel) one filtered, scaled and clamped pixel, zero
// within h of any frame edge. Flush words drain the pending outputs with zero
// color. One item is in work at a time: a pixel that yields a result passes through
// the line store read at acceptance, write back with window load, rotations of
// the window cell ring through one shared multiply-accumulate per channel, two
// scale multiply steps and the output load; a pixel that yields no result ends
// after the write back, a flush with outputs pending goes straight to the output
// load, and a flush with nothing pending ends at acceptance; the output load
// waits while the output register still holds an unaccepted word. The next item
// is taken while a result still waits in the output register. No clearing pass after reset.
`default_nettype none
module rgb_window_convolution_clamp_core
   import rwcc_pkg::*;
#(
   parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
   parameter int MAX_KERNEL      = MAX_KERNEL_DEF,
   parameter int COEF_BITS       = COEF_BITS_DEF,
   parameter int SCALE_FRAC_BITS = SCALE_FRAC_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [23:0]              req_tdata,  // red_in, green_in, blue_in
   input  wire logic                     req_tuser,  // cmd
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [23:0]              rsp_tdata,  // red_out, green_out, blue_out
   output logic                          rsp_tlast,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);
   localparam int LINES  = MAX_KERNEL - 1;
   localparam int NCELL  = MAX_KERNEL * MAX_KERNEL;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WD_W   = $clog2(MAX_WIDTH + 1);
   localparam int PEND_W = $clog2(2 * MAX_WIDTH + 4);
   localparam int KC_W   = $clog2(MAX_KERNEL);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SHIFT  = 3'd1;
   localparam logic [2:0] S_MAC    = 3'd2;
   localparam logic [2:0] S_MUL_LO = 3'd3;
   localparam logic [2:0] S_MUL_HI = 3'd4;
   localparam logic [2:0] S_FINAL  = 3'd5;

   // configuration registers
   logic [CSR_DATA_BITS-1:0] coef_ff [5];
   logic [SCALE_BITS-1:0]    scale_ff;
   logic                     large_ff;
   logic [31:0]              dims_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            coef_ff[i] <= '0;
         end
         scale_ff <= SCALE_RESET;
         large_ff <= 1'b0;
         dims_ff  <= DIMS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_COEF_0: coef_ff[0] <= csr_data;
            REG_COEF_1: coef_ff[1] <= csr_data;
            REG_COEF_2: coef_ff[2] <= csr_data;
            REG_COEF_3: coef_ff[3] <= csr_data;
            REG_COEF_4: coef_ff[4] <= csr_data;
            REG_SCALE:  scale_ff   <= csr_data[SCALE_BITS-1:0];
            REG_LARGE:  large_ff   <= csr_data[0];
            REG_DIMS:   dims_ff    <= csr_data[31:0];
            default:    ;
         endcase
      end
   end

   // frame geometry
   logic [WD_W-1:0]  fw;
   logic [15:0]      fh;
   logic             big;
   logic [1:0]       half;
   logic [KC_W-1:0]  base;
   logic [PEND_W-1:0] lag;

   always_comb begin
      if (dims_ff[15:0] == 16'd0) begin
         fw = WD_W'(1);
      end else if (dims_ff[15:0] > 16'(MAX_WIDTH)) begin
         fw = WD_W'(MAX_WIDTH);
      end else begin
         fw = WD_W'(dims_ff[15:0]);
      end
      fh   = (dims_ff[31:16] == 16'd0) ? 16'd1 : dims_ff[31:16];
      big  = large_ff && (MAX_KERNEL >= 5);
      half = big ? 2'd2 : 2'd1;
      base = big ? KC_W'(MAX_KERNEL - 5) : KC_W'(MAX_KERNEL - 3);
      lag  = big ? (PEND_W'(fw) << 1) + PEND_W'(2) : PEND_W'(fw) + PEND_W'(1);
   end

   // control state
   logic [2:0]        state_ff, state_in;
   logic [COL_W-1:0]  icol_ff, icol_in;
   logic [15:0]       irow_ff, irow_in;
   logic [COL_W-1:0]  ocol_ff, ocol_in;
   logic [15:0]       orow_ff, orow_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [KC_W-1:0]   ty_ff, ty_in, tx_ff, tx_in;
   logic              zero_ff, zero_in;
   logic              fend_ff, fend_in;
   logic              rvalid_ff, rvalid_in;
   logic [23:0]       rdata_ff, rdata_in;
   logic              rlast_ff, rlast_in;
   logic [23:0]       pix_ff;
   logic [PIX_BITS*LINES-1:0] rd_ff;
   logic [PIX_BITS*LINES-1:0] mem [MAX_WIDTH];

   logic in_acc;
   logic load_win, rot_win;
   mac_ctl_type ctl;
   logic [PIX_BITS-1:0] col [MAX_KERNEL];
   logic [PIX_BITS*LINES-1:0] wr_col;
   logic [PIX_BITS-1:0] cq [NCELL];
   logic [7:0] res_r, res_g, res_b;
   logic inside_win;
   logic [COEF_BITS-1:0] coef;
   logic [COEF_BITS+63:0] coef_ext;
   logic [KC_W-1:0] kr, kc;
   logic rsp_free;
   logic ty_last, tx_last;

   assign in_acc     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free   = !rvalid_ff || rsp_tready;

   // column through the line store
   always_comb begin
      for (int i = 0; i < LINES; i++) begin
         col[i] = rd_ff[i*PIX_BITS +: PIX_BITS];
      end
      col[LINES] = pix_ff;
      for (int i = 0; i < LINES; i++) begin
         wr_col[i*PIX_BITS +: PIX_BITS] = col[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc && !req_tuser) begin
         rd_ff  <= mem[icol_ff];
         pix_ff <= {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
      end
      if (state_ff == S_SHIFT) begin
         mem[icol_ff] <= wr_col;
      end
   end

   // window cell chain
   assign load_win = (state_ff == S_SHIFT);
   assign rot_win  = (state_ff == S_MAC);

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      localparam int GR = g / MAX_KERNEL;
      localparam int GC = g % MAX_KERNEL;
      logic [PIX_BITS-1:0] ld;
      if (GC == MAX_KERNEL - 1) begin : g_end
         assign ld = col[GR];
      end else begin : g_mid
         assign ld = cq[g+1];
      end
      rwcc_cell u_cell (
         .clock   (clock),
         .load_en (load_win),
         .rot_en  (rot_win),
         .load_d  (ld),
         .rot_d   (cq[(g+1) % NCELL]),
         .q       (cq[g])
      );
   end

   // coefficient for the tap now at the head of the chain
   always_comb begin
      kr         = ty_ff - base;
      kc         = tx_ff - base;
      inside_win = (ty_ff >= base) && (tx_ff >= base);
      coef_ext   = {{COEF_BITS{1'b0}}, 4'd0, coef_ff[kr]};
      coef       = inside_win ? coef_ext[kc*COEF_BITS +: COEF_BITS] : '0;
   end

   assign ctl.clear  = (state_ff == S_SHIFT);
   assign ctl.acc    = (state_ff == S_MAC);
   assign ctl.mul_lo = (state_ff == S_MUL_LO);
   assign ctl.mul_hi = (state_ff == S_MUL_HI);

   rwcc_mac #(.COEF_BITS(COEF_BITS), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_mac_r (
      .clock (clock), .ctl (ctl), .coef (coef), .pix (cq[0][23:16]),
      .scale (scale_ff), .result (res_r)
   );
   rwcc_mac #(.COEF_BITS(COEF_BITS), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_mac_g (
      .clock (clock), .ctl (ctl), .coef (coef), .pix (cq[0][15:8]),
      .scale (scale_ff), .result (res_g)
   );
   rwcc_mac #(.COEF_BITS(COEF_BITS), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_mac_b (
      .clock (clock), .ctl (ctl), .coef (coef), .pix (cq[0][7:0]),
      .scale (scale_ff), .result (res_b)
   );

   assign ty_last = (ty_ff == KC_W'(MAX_KERNEL - 1));
   assign tx_last = (tx_ff == KC_W'(MAX_KERNEL - 1));

   // sequencer
   always_comb begin
      state_in  = state_ff;
      icol_in   = icol_ff;
      irow_in   = irow_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      pend_in   = pend_ff;
      ty_in     = ty_ff;
      tx_in     = tx_ff;
      zero_in   = zero_ff;
      fend_in   = fend_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rdata_in  = rdata_ff;
      rlast_in  = rlast_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_acc) begin
               if (!req_tuser) begin
                  state_in = S_SHIFT;
               end else if (pend_ff != '0) begin
                  pend_in  = pend_ff - PEND_W'(1);
                  zero_in  = 1'b1;
                  fend_in  = (WD_W'(ocol_ff) == fw - WD_W'(1)) && (orow_ff == fh - 16'd1);
                  state_in = S_FINAL;
                  if (WD_W'(ocol_ff) + WD_W'(1) >= fw) begin
                     ocol_in = '0;
                     orow_in = (17'(orow_ff) + 17'd1 >= 17'(fh)) ? 16'd0 : orow_ff + 16'd1;
                  end else begin
                     ocol_in = ocol_ff + COL_W'(1);
                  end
               end
            end
         end
         S_SHIFT: begin
            if (WD_W'(icol_ff) + WD_W'(1) >= fw) begin
               icol_in = '0;
               irow_in = (17'(irow_ff) + 17'd1 >= 17'(fh)) ? 16'd0 : irow_ff + 16'd1;
            end else begin
               icol_in = icol_ff + COL_W'(1);
            end
            if (pend_ff + PEND_W'(1) > lag) begin
               fend_in = (WD_W'(ocol_ff) == fw - WD_W'(1)) && (orow_ff == fh - 16'd1);
               zero_in = !((WD_W'(ocol_ff) >= WD_W'(half)) &&
                           (WD_W'(ocol_ff) + WD_W'(half) < fw) &&
                           (orow_ff >= 16'(half)) &&
                           (17'(orow_ff) + 17'(half) < 17'(fh)));
               if (WD_W'(ocol_ff) + WD_W'(1) >= fw) begin
                  ocol_in = '0;
                  orow_in = (17'(orow_ff) + 17'd1 >= 17'(fh)) ? 16'd0 : orow_ff + 16'd1;
               end else begin
                  ocol_in = ocol_ff + COL_W'(1);
               end
               ty_in    = '0;
               tx_in    = '0;
               state_in = S_MAC;
            end else begin
               pend_in  = pend_ff + PEND_W'(1);
               state_in = S_IDLE;
            end
         end
         S_MAC: begin
            if (tx_last) begin
               tx_in = '0;
               ty_in = ty_ff + KC_W'(1);
               if (ty_last) begin
                  state_in = S_MUL_LO;
               end
            end else begin
               tx_in = tx_ff + KC_W'(1);
            end
         end
         S_MUL_LO: state_in = S_MUL_HI;
         S_MUL_HI: state_in = S_FINAL;
         S_FINAL: begin
            if (rsp_free) begin
               rvalid_in = 1'b1;
               rdata_in  = zero_ff ? 24'd0 : {res_b, res_g, res_r};
               rlast_in  = fend_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         icol_ff   <= '0;
         irow_ff   <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         pend_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         icol_ff   <= icol_in;
         irow_ff   <= irow_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
         pend_ff   <= pend_in;
         rvalid_ff <= rvalid_in;
      end
      ty_ff    <= ty_in;
      tx_ff    <= tx_in;
      zero_ff  <= zero_in;
      fend_ff  <= fend_in;
      rdata_ff <= rdata_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;
endmodule
`default_nettype wire
